// ----- src/arpr_pkg.sv -----
package arpr_pkg;

  // Opcodes of a received ARP packet
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

  // Opcodes of an emitted ARP packet
  localparam logic [1:0] OUT_OP_REQUEST = 2'd1;
  localparam logic [1:0] OUT_OP_REPLY   = 2'd2;

  // Type words used for a locally generated packet
  localparam logic [15:0] HW_TYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_TYPE_IPV4  = 16'h0800;

  // Operation of an input transaction
  localparam logic OPER_PACKET  = 1'b0;
  localparam logic OPER_RESOLVE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_MY_MAC = 1'b0;
  localparam logic CFG_MY_IP  = 1'b1;

  // Reset value of our IP address (192.168.1.40)
  localparam logic [31:0] MY_IP_RESET = 32'hC0A8_0128;

  // Store request into the address cache
  typedef struct packed {
    logic        en;
    logic [47:0] mac;
    logic [31:0] ip;
  } arpr_store_t;

  // Lookup result, valid the cycle after the lookup is issued
  typedef struct packed {
    logic        hit;
    logic [47:0] mac;
    logic [31:0] ip;
  } arpr_lookup_t;

endpackage

// ----- src/arp_responder_with_cache.sv -----
// ARP responder with a write-once address cache. A received ARP request
// teaches the sender pair and, when aimed at our IP, yields a reply; a
// received reply teaches the sender pair and then the target pair; a resolve
// looks the target up and yields a reply on a hit or a request on a miss.
// The cache is one memory of CACHE_ENTRIES entries indexed by the IP's low
// octet, with a registered read and one write port, plus valid bits that
// reset clears at once, so the block is ready right after reset. Every
// transaction passes through a second state except a packet that yields no
// result and needs at most one store (a request for another host or an
// unknown opcode), which goes straight back to idle: a resolve waits in
// S_LOOKUP for the memory read, a received reply spends S_STORE2 on the
// second store through the single write port, and a request for us spends
// S_REPLY loading the reply. A finished result sits in the output register;
// the block keeps taking transactions while it waits, and one that also has
// a result is taken and then holds the input until the output register frees.
module arp_responder_with_cache
  import arpr_pkg::*;
#(
  parameter int CACHE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_sender_ip,
  input  logic [47:0] in_target_mac,
  input  logic [31:0] in_target_ip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_dest_mac,
  output logic [47:0] out_source_mac,
  output logic [15:0] out_hw_type,
  output logic [15:0] out_proto_type,
  output logic [1:0]  out_opcode,
  output logic [47:0] out_sender_mac,
  output logic [31:0] out_sender_ip,
  output logic [47:0] out_target_mac,
  output logic [31:0] out_target_ip
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_STORE2 = 2'd2;
  localparam logic [1:0] S_REPLY  = 2'd3;

  logic [1:0]  state_r;
  logic [1:0]  state_nxt;
  logic [47:0] my_mac_r;
  logic [31:0] my_ip_r;

  logic [15:0] item_hw_r;
  logic [15:0] item_proto_r;
  logic [47:0] item_smac_r;
  logic [31:0] item_sip_r;
  logic [47:0] item_tmac_r;
  logic [31:0] item_tip_r;

  logic        out_valid_r;
  logic [47:0] out_dest_r;
  logic [15:0] out_hw_r;
  logic [15:0] out_proto_r;
  logic [1:0]  out_op_r;
  logic [47:0] out_tmac_r;
  logic [31:0] out_tip_r;
  logic [47:0] out_smac_r;
  logic [31:0] out_sip_r;

  logic         in_fire;
  logic         slot_free;
  logic         out_load;
  arpr_store_t  store;
  logic         lookup_en;
  arpr_lookup_t lookup_rsp;

  logic [47:0] res_dest;
  logic [15:0] res_hw;
  logic [15:0] res_proto;
  logic [1:0]  res_op;
  logic [47:0] res_tmac;
  logic [31:0] res_tip;

  assign in_ready  = state_r == S_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_load  = slot_free && ((state_r == S_LOOKUP) || (state_r == S_REPLY));
  assign lookup_en = in_fire && (in_operation == OPER_RESOLVE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_mac_r <= '0;
      my_ip_r  <= MY_IP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MY_MAC: my_mac_r <= cfg_wdata;
        CFG_MY_IP:  my_ip_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_hw_r    <= in_hw_type;
      item_proto_r <= in_proto_type;
      item_smac_r  <= in_sender_mac;
      item_sip_r   <= in_sender_ip;
      item_tmac_r  <= in_target_mac;
      item_tip_r   <= in_target_ip;
    end
  end

  // Store the sender pair on accept, the target pair in the next cycle
  always_comb begin
    store = '0;
    if (state_r == S_STORE2) begin
      store.en  = 1'b1;
      store.mac = item_tmac_r;
      store.ip  = item_tip_r;
    end else if (in_fire && (in_operation == OPER_PACKET) &&
                 ((in_opcode == ARP_OP_REQUEST) || (in_opcode == ARP_OP_REPLY))) begin
      store.en  = 1'b1;
      store.mac = in_sender_mac;
      store.ip  = in_sender_ip;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_operation == OPER_RESOLVE) begin
            state_nxt = S_LOOKUP;
          end else if (in_opcode == ARP_OP_REQUEST) begin
            state_nxt = (in_target_ip == my_ip_r) ? S_REPLY : S_IDLE;
          end else if (in_opcode == ARP_OP_REPLY) begin
            state_nxt = S_STORE2;
          end
        end
      end
      S_LOOKUP: if (slot_free) state_nxt = S_IDLE;
      S_REPLY:  if (slot_free) state_nxt = S_IDLE;
      S_STORE2: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Build the result from the lookup or the held request
  always_comb begin
    if (state_r == S_LOOKUP) begin
      res_hw    = HW_TYPE_ETHERNET;
      res_proto = PROTO_TYPE_IPV4;
      if (lookup_rsp.hit) begin
        res_dest = lookup_rsp.mac;
        res_op   = OUT_OP_REPLY;
        res_tmac = lookup_rsp.mac;
        res_tip  = lookup_rsp.ip;
      end else begin
        res_dest = item_tmac_r;
        res_op   = OUT_OP_REQUEST;
        res_tmac = item_tmac_r;
        res_tip  = item_tip_r;
      end
    end else begin
      res_dest  = item_smac_r;
      res_hw    = item_hw_r;
      res_proto = item_proto_r;
      res_op    = OUT_OP_REPLY;
      res_tmac  = item_smac_r;
      res_tip   = item_sip_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dest_r  <= res_dest;
      out_hw_r    <= res_hw;
      out_proto_r <= res_proto;
      out_op_r    <= res_op;
      out_tmac_r  <= res_tmac;
      out_tip_r   <= res_tip;
      out_smac_r  <= my_mac_r;
      out_sip_r   <= my_ip_r;
    end
  end

  arpr_cache #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_cache (
    .clk       (clk),
    .rst_n     (rst_n),
    .my_mac    (my_mac_r),
    .my_ip     (my_ip_r),
    .store     (store),
    .lookup_en (lookup_en),
    .lookup_ip (in_target_ip),
    .lookup_rsp(lookup_rsp)
  );

  assign out_valid      = out_valid_r;
  assign out_dest_mac   = out_dest_r;
  assign out_source_mac = out_smac_r;
  assign out_hw_type    = out_hw_r;
  assign out_proto_type = out_proto_r;
  assign out_opcode     = out_op_r;
  assign out_sender_mac = out_smac_r;
  assign out_sender_ip  = out_sip_r;
  assign out_target_mac = out_tmac_r;
  assign out_target_ip  = out_tip_r;

  // A resolve always goes through the memory read cycle
  a_resolve_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OPER_RESOLVE) |=> state_r == S_LOOKUP)
    else $error("resolve transaction skipped the lookup cycle");

  // A result is loaded only from a state that owns one
  a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == S_LOOKUP) || (state_r == S_REPLY))
    else $error("output loaded outside a result state");

  // The second store state is always followed by idle
  a_store2_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STORE2 |=> state_r == S_IDLE)
    else $error("second store did not return to idle");

  // An emitted opcode is a request or a reply
  a_out_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_opcode == OUT_OP_REQUEST) || (out_opcode == OUT_OP_REPLY))
    else $error("illegal opcode on the output");

endmodule

// ----- src/arpr_cache.sv -----
module arpr_cache
  import arpr_pkg::*;
#(
  parameter int CACHE_ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [47:0]  my_mac,
  input  logic [31:0]  my_ip,
  input  arpr_store_t  store,
  input  logic         lookup_en,
  input  logic [31:0]  lookup_ip,
  output arpr_lookup_t lookup_rsp
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);

  // Entry layout: IP high half, MAC, IP low half
  logic [79:0]              entry_mem_r [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_r;
  logic [79:0]              rd_data_r;
  logic                     own_r;
  logic                     vhit_r;

  logic [7:0]       st_octet;
  logic [IDX_W-1:0] st_idx;
  logic             st_ok;
  logic [7:0]       lk_octet;
  logic [IDX_W-1:0] lk_idx;
  logic             lk_in_range;

  // Write-once store: skip own index, out-of-range octets and valid entries
  assign st_octet = store.ip[7:0];
  assign st_idx   = store.ip[IDX_W-1:0];
  assign st_ok    = store.en && (st_octet != my_ip[7:0]) &&
                    (int'(st_octet) < CACHE_ENTRIES) && !valid_r[st_idx];

  assign lk_octet    = lookup_ip[7:0];
  assign lk_idx      = lookup_ip[IDX_W-1:0];
  assign lk_in_range = int'(lk_octet) < CACHE_ENTRIES;

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (st_ok) begin
      valid_r[st_idx] <= 1'b1;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (st_ok) begin
      entry_mem_r[st_idx] <= {store.ip[31:16], store.mac, store.ip[15:0]};
    end
    if (lookup_en) begin
      rd_data_r <= entry_mem_r[lk_idx];
    end
  end

  // Capture hit status alongside the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r  <= 1'b0;
      vhit_r <= 1'b0;
    end else if (lookup_en) begin
      own_r  <= lk_octet == my_ip[7:0];
      vhit_r <= lk_in_range && valid_r[lk_idx];
    end
  end

  // Own index always reads as our current pair
  always_comb begin
    lookup_rsp.hit = own_r || vhit_r;
    lookup_rsp.mac = own_r ? my_mac : rd_data_r[63:16];
    lookup_rsp.ip  = own_r ? my_ip  : {rd_data_r[79:64], rd_data_r[15:0]};
  end

endmodule
